/* hdl/gp2joy_pkg.sv */
`default_nettype none

package gp2joy_pkg;

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_PRESS_TIME = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [8:0] DEADZONE_RST = 9'd50;
  localparam logic [9:0] PRESS_TIME_RST = 10'd30;
  localparam logic [15:0] PERIOD_RST = 16'd200;

  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2,
    PH_SLEEP   = 2'd3
  } phase_e;

  typedef struct packed {
    logic fire;
    logic right;
    logic left;
    logic down;
    logic up;
  } lines_t;

  typedef struct packed {
    lines_t      held;
    logic        en;
    phase_e      phase;
    logic [15:0] cnt;
    logic        wake;
  } port_state_t;

  localparam port_state_t ST_RESET = '{
    held:  '0,
    en:    1'b0,
    phase: PH_IDLE,
    cnt:   16'd0,
    wake:  1'b1
  };

  typedef struct packed {
    logic [8:0]  deadzone;
    logic [9:0]  press_time;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic              port;
    logic              pad_up;
    logic              pad_down;
    logic              pad_left;
    logic              pad_right;
    logic              button_a;
    logic              button_b;
    logic              button_x;
    logic              button_y;
    logic signed [9:0] stick_x;
    logic signed [9:0] stick_y;
  } item_t;

  typedef struct packed {
    logic joy_up;
    logic joy_down;
    logic joy_left;
    logic joy_right;
    logic joy_fire;
    logic autofire_on;
  } res_t;

endpackage

`default_nettype wire

/* hdl/gp2joy_cfg.sv */
`default_nettype none

module gp2joy_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gp2joy_pkg::cfg_t  cfg_o
);
  import gp2joy_pkg::*;

  logic [8:0]  deadzone_q;
  logic [9:0]  press_time_q;
  logic [15:0] period_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q   <= DEADZONE_RST;
      press_time_q <= PRESS_TIME_RST;
      period_q     <= PERIOD_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_DEADZONE:   deadzone_q <= pwdata[8:0];
        REG_PRESS_TIME: press_time_q <= pwdata[9:0];
        REG_PERIOD:     period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEADZONE:   prdata = {23'd0, deadzone_q};
      REG_PRESS_TIME: prdata = {22'd0, press_time_q};
      REG_PERIOD:     prdata = {16'd0, period_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{deadzone: deadzone_q, press_time: press_time_q, period: period_q};

endmodule

`default_nettype wire

/* hdl/gp2joy_engine.sv */
`default_nettype none

module gp2joy_engine #(
  parameter int PORTS = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  gp2joy_pkg::item_t  item_i,
  input  gp2joy_pkg::cfg_t   cfg_i,
  output gp2joy_pkg::res_t   res_o
);
  import gp2joy_pkg::*;

  port_state_t      st_q [PORTS];
  port_state_t      cur;
  port_state_t      nxt;
  logic [PORTS-1:0] sel;
  logic             hit;
  logic [9:0]       plen;
  logic signed [17:0] slen;
  logic [9:0]       ax;
  logic [9:0]       ay;
  logic             stick_on;
  lines_t           lines;

  // Start of an autofire cycle: press again if still enabled, else go idle.
  function automatic port_state_t cycle_top(port_state_t s, logic [9:0] pl);
    port_state_t r;
    r = s;
    if (s.en) begin
      r.phase = PH_PRESS;
      r.cnt   = {6'd0, pl};
    end else begin
      r.phase = PH_IDLE;
      r.cnt   = 16'd0;
    end
    return r;
  endfunction

  always_comb begin
    sel = '0;
    cur = ST_RESET;
    for (int i = 0; i < PORTS; i++) begin
      sel[i] = ({31'd0, item_i.port} == 32'(i));
      if (sel[i]) begin
        cur = st_q[i];
      end
    end
    hit = |sel;
  end

  // Stick decode: an axis's direction is taken when the other axis is less than twice it.
  always_comb begin
    ax = item_i.stick_x[9] ? (~item_i.stick_x + 10'd1) : item_i.stick_x;
    ay = item_i.stick_y[9] ? (~item_i.stick_y + 10'd1) : item_i.stick_y;
    stick_on = (ax > {1'b0, cfg_i.deadzone}) || (ay > {1'b0, cfg_i.deadzone});
    lines.up    = item_i.pad_up || item_i.button_b;
    lines.down  = item_i.pad_down || item_i.button_x;
    lines.left  = item_i.pad_left;
    lines.right = item_i.pad_right;
    lines.fire  = item_i.button_a;
    if (stick_on) begin
      if ({1'b0, ay} < {ax, 1'b0}) begin
        if (item_i.stick_x[9]) lines.left = 1'b1;
        else lines.right = 1'b1;
      end
      if ({1'b0, ax} < {ay, 1'b0}) begin
        if (item_i.stick_y[9]) lines.up = 1'b1;
        else lines.down = 1'b1;
      end
    end
  end

  always_comb begin
    plen = (cfg_i.press_time == 10'd0) ? 10'd1 : cfg_i.press_time;
    slen = $signed({2'b00, cfg_i.period}) - $signed({7'd0, plen, 1'b0});
    nxt = cur;
    if (item_i.func == FUNC_TICK) begin
      unique case (cur.phase)
        PH_IDLE: begin
          nxt = cycle_top(cur, plen);
        end
        PH_PRESS: begin
          if (cur.cnt <= 16'd1) begin
            nxt.phase = PH_RELEASE;
            nxt.cnt   = {6'd0, plen};
          end else begin
            nxt.cnt = cur.cnt - 16'd1;
          end
        end
        PH_RELEASE: begin
          if (cur.cnt <= 16'd1) begin
            if (cur.wake) begin
              nxt.wake = 1'b0;
              nxt = cycle_top(nxt, plen);
            end else if (slen <= 18'sd0) begin
              nxt = cycle_top(cur, plen);
            end else begin
              nxt.phase = PH_SLEEP;
              nxt.cnt   = slen[15:0];
            end
          end else begin
            nxt.cnt = cur.cnt - 16'd1;
          end
        end
        PH_SLEEP: begin
          if (cur.wake) begin
            nxt.wake = 1'b0;
            nxt = cycle_top(nxt, plen);
          end else if (cur.cnt <= 16'd1) begin
            nxt = cycle_top(cur, plen);
          end else begin
            nxt.cnt = cur.cnt - 16'd1;
          end
        end
        default: ;
      endcase
    end else begin
      nxt.held = lines;
      if (item_i.button_y) begin
        if (!cur.en) begin
          nxt.en   = 1'b1;
          nxt.wake = 1'b1;
        end
      end else begin
        nxt.en = 1'b0;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (hit) begin
      res_o.joy_up      = nxt.held.up;
      res_o.joy_down    = nxt.held.down;
      res_o.joy_left    = nxt.held.left;
      res_o.joy_right   = nxt.held.right;
      res_o.joy_fire    = nxt.held.fire || (nxt.phase == PH_PRESS);
      res_o.autofire_on = nxt.en;
    end
  end

  for (genvar g = 0; g < PORTS; g++) begin : g_port
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[g] <= ST_RESET;
      end else if (upd_i && sel[g]) begin
        st_q[g] <= nxt;
      end
    end
  end

`ifndef SYNTH
  for (genvar g = 0; g < PORTS; g++) begin : g_chk
    // An idle port has no countdown running; any other phase has one.
    a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (st_q[g].phase == PH_IDLE) == (st_q[g].cnt == 16'd0))
      else $error("countdown does not match the autofire phase");
    a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (upd_i && sel[g] && item_i.func == FUNC_REPORT && !item_i.button_y)
      |=> !st_q[g].en)
      else $error("report without Y left autofire enabled");
    a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (upd_i && sel[g] && item_i.func == FUNC_REPORT && item_i.button_y && !st_q[g].en)
      |=> (st_q[g].en && st_q[g].wake))
      else $error("autofire start did not arm the wake");
  end
`endif

endmodule

`default_nettype wire

/* hdl/gamepad_to_joystick_autofire_top.sv */
`default_nettype none

// Gamepad to joystick adapter with autofire for up to PORTS joystick ports.
// Each input word is either a gamepad report, which sets the port's direction
// and fire lines from dpad, buttons and stick, or a timer tick, which advances
// that port's autofire sequence. Every word yields one result word with the
// port's lines after the update. A word is held in an input register, then
// passes through the decode and timer logic into the output register, so the
// block takes one word per clock while the output is not stalled; the output
// register lets the next word enter while a result is still waiting. Registers
// must be written over the APB port only while no word is in flight; the block
// itself does not enforce this.
module gamepad_to_joystick_autofire_top #(
  parameter int PORTS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic              port_i,
  input  logic              pad_up_i,
  input  logic              pad_down_i,
  input  logic              pad_left_i,
  input  logic              pad_right_i,
  input  logic              button_a_i,
  input  logic              button_b_i,
  input  logic              button_x_i,
  input  logic              button_y_i,
  input  logic signed [9:0] stick_x_i,
  input  logic signed [9:0] stick_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              joy_up_o,
  output logic              joy_down_o,
  output logic              joy_left_o,
  output logic              joy_right_o,
  output logic              joy_fire_o,
  output logic              autofire_on_o
);
  import gp2joy_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_q;
  logic  s1_valid_q;
  logic  s1_valid_d;
  logic  out_valid_q;
  logic  out_valid_d;
  res_t  res;
  res_t  res_q;
  logic  in_acc;
  logic  adv;

  gp2joy_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item = '{
    func:      func_i,
    port:      port_i,
    pad_up:    pad_up_i,
    pad_down:  pad_down_i,
    pad_left:  pad_left_i,
    pad_right: pad_right_i,
    button_a:  button_a_i,
    button_b:  button_b_i,
    button_x:  button_x_i,
    button_y:  button_y_i,
    stick_x:   stick_x_i,
    stick_y:   stick_y_i
  };

  // The held word moves on whenever the output register is free or drains.
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  gp2joy_engine #(
    .PORTS (PORTS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv),
    .item_i (s1_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o   = out_valid_q;
  assign joy_up_o      = res_q.joy_up;
  assign joy_down_o    = res_q.joy_down;
  assign joy_left_o    = res_q.joy_left;
  assign joy_right_o   = res_q.joy_right;
  assign joy_fire_o    = res_q.joy_fire;
  assign autofire_on_o = res_q.autofire_on;

`ifndef SYNTH
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word was not held in the input register");
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed word did not reach the output register");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input register changed while the output was stalled");
`endif

endmodule

`default_nettype wire
